### hw/rtl/tep_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the terminal escape parser.
// ---------------------------------------------------------------------------
package tep_pkg;

    localparam int MAX_PARAMS_DEF = 8;
    localparam int PARAM_W        = 16;
    localparam int CP_W           = 21;

    // screen command codes
    typedef enum logic [3:0] {
        CMD_WRITE       = 4'd0,
        CMD_UP          = 4'd1,
        CMD_DOWN        = 4'd2,
        CMD_FORWARD     = 4'd3,
        CMD_BACK        = 4'd4,
        CMD_POSITION    = 4'd5,
        CMD_TAB         = 4'd6,
        CMD_LINEFEED    = 4'd7,
        CMD_RETURN      = 4'd8,
        CMD_RESET       = 4'd9,
        CMD_CLEARSCREEN = 4'd10,
        CMD_CLEARLINE   = 4'd11
    } t_cmd_e;

    // parser modes
    typedef enum logic [1:0] {
        MODE_GROUND = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_OSC    = 2'd3
    } t_mode_e;

    // byte codes
    localparam logic [7:0] B_BS   = 8'h08;
    localparam logic [7:0] B_HT   = 8'h09;
    localparam logic [7:0] B_LF   = 8'h0A;
    localparam logic [7:0] B_FF   = 8'h0C;
    localparam logic [7:0] B_CR   = 8'h0D;
    localparam logic [7:0] B_BEL  = 8'h07;
    localparam logic [7:0] B_ESC  = 8'h1B;
    localparam logic [7:0] B_CSI  = 8'h9B;
    localparam logic [7:0] B_OSC  = 8'h9D;
    localparam logic [7:0] B_ST   = 8'h9C;
    localparam logic [7:0] B_LBR  = 8'h5B;
    localparam logic [7:0] B_RBR  = 8'h5D;
    localparam logic [7:0] B_LC_C = 8'h63;
    localparam logic [7:0] B_SEMI = 8'h3B;
    localparam logic [7:0] B_ZERO = 8'h30;
    localparam logic [7:0] B_NINE = 8'h39;
    localparam logic [7:0] B_FIN_LO = 8'h40;
    localparam logic [7:0] B_FIN_HI = 8'h7E;
    localparam logic [7:0] B_SPACE  = 8'h20;
    localparam logic [7:0] F_A = 8'h41;
    localparam logic [7:0] F_B = 8'h42;
    localparam logic [7:0] F_C = 8'h43;
    localparam logic [7:0] F_D = 8'h44;
    localparam logic [7:0] F_H = 8'h48;
    localparam logic [7:0] F_J = 8'h4A;
    localparam logic [7:0] F_K = 8'h4B;
    localparam logic [7:0] F_F = 8'h66;
    localparam logic [7:0] F_M = 8'h6D;

    // sgr codes
    localparam logic [15:0] SGR_RESET  = 16'd0;
    localparam logic [15:0] SGR_BOLD   = 16'd1;
    localparam logic [15:0] SGR_FG_LO  = 16'd30;
    localparam logic [15:0] SGR_FG_HI  = 16'd37;
    localparam logic [15:0] SGR_FG_EXT = 16'd38;
    localparam logic [15:0] SGR_IDX    = 16'd5;

    // one result beat
    typedef struct packed {
        t_cmd_e            command;
        logic [CP_W-1:0]   code_point;
        logic [15:0]       move_count;
        logic [15:0]       target_row;
        logic [15:0]       target_col;
        logic              style_bold;
        logic              style_fg_indexed;
        logic [7:0]        style_fg_index;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic walk;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic sgr_req;
        logic walk_done;
        logic emit;
    } t_dp_status;

    // output buffer status
    typedef struct packed {
        logic full;
        logic valid;
    } t_buf_status;

endpackage

### hw/rtl/tep_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tep_if
// Valid/ready channels for input bytes and screen commands.
// ---------------------------------------------------------------------------
interface tep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface tep_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [20:0] code_point;
    logic [15:0] move_count;
    logic [15:0] target_row;
    logic [15:0] target_col;
    logic        style_bold;
    logic        style_fg_indexed;
    logic [7:0]  style_fg_index;

    modport source (output valid, output command, output code_point, output move_count,
                    output target_row, output target_col, output style_bold,
                    output style_fg_indexed, output style_fg_index, input ready);
    modport sink   (input valid, input command, input code_point, input move_count,
                    input target_row, input target_col, input style_bold,
                    input style_fg_indexed, input style_fg_index, output ready);
endinterface

### hw/rtl/tep_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tep_ctrl
// Controller: takes byte beats and sequences the sgr parameter walk.
// ---------------------------------------------------------------------------
module tep_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tep_pkg::t_dp_status  i_status,
    input  tep_pkg::t_buf_status i_buf,
    output tep_pkg::t_ctl_cmd    o_cmd
);
    import tep_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state_e;

    t_state_e r_state, n_state;

    // ready when idle and the output buffer has room
    assign o_ready      = (r_state == ST_IDLE) && !i_buf.full;
    assign o_cmd.accept = o_ready && i_valid;
    assign o_cmd.walk   = (r_state == ST_WALK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_status.sgr_req) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.walk_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/tep_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tep_datapath
// Parser state, utf-8 decoder, csi parameters, sgr style and result build.
// ---------------------------------------------------------------------------
module tep_datapath #(
    parameter int MAX_PARAMS = tep_pkg::MAX_PARAMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_byte,
    input  tep_pkg::t_ctl_cmd   i_cmd,
    output tep_pkg::t_dp_status o_status,
    output tep_pkg::t_result    o_result
);
    import tep_pkg::*;

    localparam int PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int I2 = (MAX_PARAMS > 2) ? 2 : 0;

    t_mode_e          r_mode, n_mode;
    logic [1:0]       r_left, n_left;
    logic [CP_W-1:0]  r_accum, n_accum;
    logic [15:0]      r_pv [MAX_PARAMS];
    logic [15:0]      n_pv [MAX_PARAMS];
    logic [CW-1:0]    r_pc, n_pc;
    logic             r_drop, n_drop;
    logic [CW-1:0]    r_rem, n_rem;
    logic             r_bold, n_bold;
    logic             r_fgi, n_fgi;
    logic [7:0]       r_fgx, n_fgx;

    logic [CW-1:0]    pc_m1;
    logic [PW-1:0]    idx;
    logic [15:0]      cur;
    logic [19:0]      acc10;
    logic [15:0]      p0, p1;
    logic             skip3;
    logic             emit;
    logic             sgr_req;
    t_result          res;
    logic [7:0]       ch;

    assign ch    = i_byte;
    assign pc_m1 = r_pc - CW'(1);
    assign idx   = pc_m1[PW-1:0];
    assign cur   = r_pv[idx];
    // value times ten plus digit, by shift and add
    assign acc10 = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {16'd0, ch[3:0]};
    assign p0    = r_pv[0];
    assign p1    = (r_pc > CW'(1)) ? r_pv[(MAX_PARAMS > 1) ? 1 : 0] : 16'd0;
    assign skip3 = (r_rem > CW'(2)) && (r_pv[0] == SGR_FG_EXT)
                   && (r_pv[(MAX_PARAMS > 1) ? 1 : 0] == SGR_IDX);

    // next state and result for one byte, or one sgr walk step
    always_comb begin
        n_mode  = r_mode;
        n_left  = r_left;
        n_accum = r_accum;
        n_pv    = r_pv;
        n_pc    = r_pc;
        n_drop  = r_drop;
        n_rem   = r_rem;
        n_bold  = r_bold;
        n_fgi   = r_fgi;
        n_fgx   = r_fgx;
        emit    = 1'b0;
        sgr_req = 1'b0;
        res            = '0;
        res.command    = CMD_WRITE;

        if (i_cmd.walk) begin
            // one parameter per cycle, or all three of 38;5;n, array shifts toward index zero
            if (r_pv[0] == SGR_RESET) begin
                n_bold = 1'b0; n_fgi = 1'b0; n_fgx = 8'd0;
            end else if (r_pv[0] == SGR_BOLD) begin
                n_bold = 1'b1;
            end else if (r_pv[0] >= SGR_FG_LO && r_pv[0] <= SGR_FG_HI) begin
                n_fgx = 8'(r_pv[0] - SGR_FG_LO);
                n_fgi = 1'b1;
            end else if (skip3) begin
                n_fgx = (r_pv[I2] > 16'd255) ? 8'd255 : r_pv[I2][7:0];
                n_fgi = 1'b1;
            end
            for (int k = 0; k < MAX_PARAMS; k++) begin
                n_pv[k] = 16'd0;
                if (skip3) begin
                    if (k + 3 < MAX_PARAMS) n_pv[k] = r_pv[(k + 3) % MAX_PARAMS];
                end else begin
                    if (k + 1 < MAX_PARAMS) n_pv[k] = r_pv[(k + 1) % MAX_PARAMS];
                end
            end
            n_rem = skip3 ? (r_rem - CW'(3)) : (r_rem - CW'(1));
        end else if (i_cmd.accept) begin
            if (r_left != 2'd0 && ch[7:6] == 2'b10) begin
                // utf-8 continuation
                n_accum = {r_accum[CP_W-7:0], ch[5:0]};
                n_left  = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    emit           = 1'b1;
                    res.command    = CMD_WRITE;
                    res.code_point = {r_accum[CP_W-7:0], ch[5:0]};
                end
            end else if (ch[7:5] == 3'b110) begin
                n_accum = {16'd0, ch[4:0]};
                n_left  = 2'd1;
            end else if (ch[7:4] == 4'b1110) begin
                n_accum = {17'd0, ch[3:0]};
                n_left  = 2'd2;
            end else if (ch[7:3] == 5'b11110) begin
                n_accum = {18'd0, ch[2:0]};
                n_left  = 2'd3;
            end else begin
                n_left = 2'd0;
                unique case (r_mode)
                    MODE_GROUND: begin
                        emit = 1'b1;
                        if (ch == B_ESC) begin
                            n_mode = MODE_ESCAPE; emit = 1'b0;
                        end else if (ch == B_CSI) begin
                            n_mode = MODE_CSI; emit = 1'b0;
                            for (int k = 0; k < MAX_PARAMS; k++) n_pv[k] = 16'd0;
                            n_pc = CW'(1); n_drop = 1'b0;
                        end else if (ch == B_OSC) begin
                            n_mode = MODE_OSC; emit = 1'b0;
                        end else if (ch == B_BS) begin
                            res.command = CMD_BACK; res.move_count = 16'd1;
                        end else if (ch == B_HT) begin
                            res.command = CMD_TAB;
                        end else if (ch == B_LF || ch == B_FF) begin
                            res.command = CMD_LINEFEED;
                        end else if (ch == B_CR) begin
                            res.command = CMD_RETURN;
                        end else if (ch >= B_SPACE && ch <= B_FIN_HI) begin
                            res.command = CMD_WRITE; res.code_point = {13'd0, ch};
                        end else begin
                            emit = 1'b0;
                        end
                    end
                    MODE_ESCAPE: begin
                        n_mode = MODE_GROUND;
                        if (ch == B_LBR) begin
                            n_mode = MODE_CSI;
                            for (int k = 0; k < MAX_PARAMS; k++) n_pv[k] = 16'd0;
                            n_pc = CW'(1); n_drop = 1'b0;
                        end else if (ch == B_RBR) begin
                            n_mode = MODE_OSC;
                        end else if (ch == B_LC_C) begin
                            emit = 1'b1; res.command = CMD_RESET;
                        end
                    end
                    MODE_CSI: begin
                        if (ch >= B_FIN_LO && ch <= B_FIN_HI) begin
                            n_mode = MODE_GROUND;
                            res.move_count = (p0 == 16'd0) ? 16'd1 : p0;
                            case (ch)
                                F_A: begin emit = 1'b1; res.command = CMD_UP; end
                                F_B: begin emit = 1'b1; res.command = CMD_DOWN; end
                                F_C: begin emit = 1'b1; res.command = CMD_FORWARD; end
                                F_D: begin emit = 1'b1; res.command = CMD_BACK; end
                                F_H, F_F: begin
                                    emit = 1'b1; res.command = CMD_POSITION;
                                    res.move_count = 16'd0;
                                    res.target_row = (p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
                                    res.target_col = (p1 != 16'd0) ? p1 - 16'd1 : 16'd0;
                                end
                                F_J: begin
                                    emit = 1'b1; res.command = CMD_CLEARSCREEN;
                                    res.move_count = 16'd0;
                                end
                                F_K: begin
                                    emit = 1'b1; res.command = CMD_CLEARLINE;
                                    res.move_count = 16'd0;
                                end
                                F_M: begin
                                    sgr_req = 1'b1;
                                    n_rem   = r_pc;
                                end
                                default: ;
                            endcase
                        end else if (ch >= B_ZERO && ch <= B_NINE) begin
                            if (!r_drop && r_pc >= CW'(1) && r_pc <= CW'(MAX_PARAMS)) begin
                                n_pv[idx] = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                            end
                        end else if (ch == B_SEMI) begin
                            if (r_pc < CW'(MAX_PARAMS)) n_pc = r_pc + CW'(1);
                            else n_drop = 1'b1;
                        end
                    end
                    MODE_OSC: begin
                        if (ch == B_BEL || ch == B_ST) n_mode = MODE_GROUND;
                        else if (ch == B_ESC) n_mode = MODE_ESCAPE;
                    end
                    default: ;
                endcase
            end
        end

        res.style_bold       = r_bold;
        res.style_fg_indexed = r_fgi;
        res.style_fg_index   = r_fgx;
    end

    assign o_status.sgr_req   = sgr_req;
    assign o_status.walk_done = (n_rem == '0);
    assign o_status.emit      = emit && i_cmd.accept;
    assign o_result           = res;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GROUND;
            r_left  <= 2'd0;
            r_accum <= '0;
            for (int k = 0; k < MAX_PARAMS; k++) r_pv[k] <= 16'd0;
            r_pc    <= '0;
            r_drop  <= 1'b0;
            r_rem   <= '0;
            r_bold  <= 1'b0;
            r_fgi   <= 1'b0;
            r_fgx   <= 8'd0;
        end else begin
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_accum <= n_accum;
            r_pv    <= n_pv;
            r_pc    <= n_pc;
            r_drop  <= n_drop;
            r_rem   <= n_rem;
            r_bold  <= n_bold;
            r_fgi   <= n_fgi;
            r_fgx   <= n_fgx;
        end
    end

endmodule

### hw/rtl/tep_out_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tep_out_buf
// Two-entry output buffer: output register plus skid stage.
// ---------------------------------------------------------------------------
module tep_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tep_pkg::t_result     i_data,
    input  logic                 i_pop,
    output tep_pkg::t_result     o_data,
    output tep_pkg::t_buf_status o_status
);
    import tep_pkg::*;

    t_result r_main, n_main, r_skid, n_skid;
    logic    r_mv, n_mv, r_sv, n_sv;

    assign o_data          = r_main;
    assign o_status.valid  = r_mv;
    assign o_status.full   = r_sv;

    // fill main first, overflow into skid
    always_comb begin
        n_main = r_main;
        n_skid = r_skid;
        n_mv   = r_mv;
        n_sv   = r_sv;
        if (i_pop) begin
            if (r_sv) begin
                n_main = r_skid;
                n_sv   = i_push;
                n_skid = i_data;
            end else begin
                n_mv   = i_push;
                n_main = i_data;
            end
        end else if (!r_mv) begin
            n_mv   = i_push;
            n_main = i_data;
        end else if (i_push) begin
            n_sv   = 1'b1;
            n_skid = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_mv <= n_mv;
            r_sv <= n_sv;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

### hw/rtl/terminal_escape_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// terminal_escape_parser
// Terminal byte stream decoder producing styled screen commands.
// ---------------------------------------------------------------------------
// output: each result is registered in the output buffer before it reaches o_cmd
// throughput: one byte per cycle while the command side keeps up, except an sgr
//   final 'm', which then holds input ready low until all of its walk steps are done
// a walk step takes one stored parameter, or all three of 38;5;n (up to MAX_PARAMS)
// reset: synchronous active low, clears mode, utf-8, parameters and style
module terminal_escape_parser #(
    parameter int MAX_PARAMS = tep_pkg::MAX_PARAMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tep_byte_if.sink       i_byte,
    tep_cmd_if.source      o_cmd
);
    import tep_pkg::*;

    t_ctl_cmd    ctl_cmd;
    t_dp_status  dp_status;
    t_buf_status buf_status;
    t_result     dp_result;
    t_result     out_data;

    tep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_byte.valid),
        .o_ready  (i_byte.ready),
        .i_status (dp_status),
        .i_buf    (buf_status),
        .o_cmd    (ctl_cmd)
    );

    tep_datapath #(.MAX_PARAMS(MAX_PARAMS)) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte.byte_in),
        .i_cmd    (ctl_cmd),
        .o_status (dp_status),
        .o_result (dp_result)
    );

    tep_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (dp_status.emit),
        .i_data   (dp_result),
        .i_pop    (o_cmd.valid && o_cmd.ready),
        .o_data   (out_data),
        .o_status (buf_status)
    );

    assign o_cmd.valid            = buf_status.valid;
    assign o_cmd.command          = out_data.command;
    assign o_cmd.code_point       = out_data.code_point;
    assign o_cmd.move_count       = out_data.move_count;
    assign o_cmd.target_row       = out_data.target_row;
    assign o_cmd.target_col       = out_data.target_col;
    assign o_cmd.style_bold       = out_data.style_bold;
    assign o_cmd.style_fg_indexed = out_data.style_fg_indexed;
    assign o_cmd.style_fg_index   = out_data.style_fg_index;

`ifndef ASSERT_OFF
    // no byte taken during the sgr walk
    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.walk |-> !i_byte.ready)
        else $error("byte accepted during sgr walk");

    // skid stage only holds data behind a valid output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_status.full |-> buf_status.valid)
        else $error("skid filled with empty output register");

    // after an emitted result the output is valid next cycle
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.emit |=> o_cmd.valid)
        else $error("emitted result lost");
`endif

endmodule

### bench/terminal_escape_parser_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// terminal_escape_parser_tb
// Drives terminal byte streams into the escape parser and checks every
// screen command beat against a behavioral decoder kept in the bench.
// Random gaps on the byte side and random stalls on the command side.
// ---------------------------------------------------------------------------
module terminal_escape_parser_tb;
    import tep_pkg::*;

    localparam int NPARAM = MAX_PARAMS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tep_byte_if byte_ch ();
    tep_cmd_if  cmd_ch ();

    terminal_escape_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_cmd   (cmd_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state mirrored in the bench
    t_mode_e     mode_q;
    logic [1:0]  u8_left;
    logic [20:0] u8_acc;
    logic [15:0] params [NPARAM];
    int          pcount;
    bit          pdrop;
    logic        st_bold, st_idx_on;
    logic [7:0]  st_idx;

    t_result expected_cmds [$];
    int      error_count = 0;
    int      sent_count = 0;
    int      stall_left = 0;
    longint  cycle_count = 0;
    bit      stall_enable = 1'b1;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic void decoder_reset();
        mode_q = MODE_GROUND;
        u8_left = 0;
        u8_acc = 0;
        foreach (params[i]) params[i] = 0;
        pcount = 0;
        pdrop = 0;
        st_bold = 0;
        st_idx_on = 0;
        st_idx = 0;
    endfunction

    function automatic void push_cmd(t_cmd_e c, logic [20:0] cp, logic [15:0] cnt,
                                     logic [15:0] row, logic [15:0] col);
        t_result r;
        r.command = c;
        r.code_point = cp;
        r.move_count = cnt;
        r.target_row = row;
        r.target_col = col;
        r.style_bold = st_bold;
        r.style_fg_indexed = st_idx_on;
        r.style_fg_index = st_idx;
        expected_cmds = {expected_cmds, r};
    endfunction

    function automatic void clear_params();
        foreach (params[i]) params[i] = 0;
        pcount = 1;
        pdrop = 0;
    endfunction

    function automatic void apply_style();
        int i;
        logic [15:0] code;
        i = 0;
        while (i < pcount && i < NPARAM) begin
            code = params[i];
            if (code == SGR_RESET) begin
                st_bold = 0;
                st_idx_on = 0;
                st_idx = 0;
            end else if (code == SGR_BOLD) begin
                st_bold = 1;
            end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
                st_idx = 8'(code - SGR_FG_LO);
                st_idx_on = 1;
            end else if (code == SGR_FG_EXT) begin
                if (i + 2 < pcount && i + 2 < NPARAM && params[i+1] == SGR_IDX) begin
                    st_idx = params[i+2] > 255 ? 8'd255 : 8'(params[i+2]);
                    st_idx_on = 1;
                    i += 2;
                end
            end
            i++;
        end
    endfunction

    function automatic void csi_final(logic [7:0] ch);
        logic [15:0] p0, p1, n;
        p0 = params[0];
        p1 = pcount > 1 ? params[1] : 16'd0;
        n = p0 == 0 ? 16'd1 : p0;
        case (ch)
            F_A: push_cmd(CMD_UP, 0, n, 0, 0);
            F_B: push_cmd(CMD_DOWN, 0, n, 0, 0);
            F_C: push_cmd(CMD_FORWARD, 0, n, 0, 0);
            F_D: push_cmd(CMD_BACK, 0, n, 0, 0);
            F_H, F_F: push_cmd(CMD_POSITION, 0, 0, p0 > 0 ? p0 - 16'd1 : 16'd0,
                               p1 > 0 ? p1 - 16'd1 : 16'd0);
            F_J: push_cmd(CMD_CLEARSCREEN, 0, 0, 0, 0);
            F_K: push_cmd(CMD_CLEARLINE, 0, 0, 0, 0);
            F_M: apply_style();
            default: ;
        endcase
    endfunction

    // advance the decoder by one byte and queue any command it yields
    function automatic void decode_byte(logic [7:0] ch);
        int v;
        if (u8_left > 0) begin
            if ((ch & 8'hC0) == 8'h80) begin
                u8_acc = {u8_acc[14:0], ch[5:0]};
                u8_left--;
                if (u8_left == 0) push_cmd(CMD_WRITE, u8_acc, 0, 0, 0);
                return;
            end
            u8_left = 0;
        end
        if ((ch & 8'hE0) == 8'hC0) begin
            u8_acc = 21'(ch & 8'h1F); u8_left = 1; return;
        end
        if ((ch & 8'hF0) == 8'hE0) begin
            u8_acc = 21'(ch & 8'h0F); u8_left = 2; return;
        end
        if ((ch & 8'hF8) == 8'hF0) begin
            u8_acc = 21'(ch & 8'h07); u8_left = 3; return;
        end
        case (mode_q)
            MODE_GROUND: begin
                if (ch == B_ESC) mode_q = MODE_ESCAPE;
                else if (ch == B_CSI) begin
                    mode_q = MODE_CSI;
                    clear_params();
                end else if (ch == B_OSC) mode_q = MODE_OSC;
                else if (ch == B_BS) push_cmd(CMD_BACK, 0, 1, 0, 0);
                else if (ch == B_HT) push_cmd(CMD_TAB, 0, 0, 0, 0);
                else if (ch == B_LF || ch == B_FF) push_cmd(CMD_LINEFEED, 0, 0, 0, 0);
                else if (ch == B_CR) push_cmd(CMD_RETURN, 0, 0, 0, 0);
                else if (ch >= B_SPACE && ch <= B_FIN_HI)
                    push_cmd(CMD_WRITE, 21'(ch), 0, 0, 0);
            end
            MODE_ESCAPE: begin
                mode_q = MODE_GROUND;
                if (ch == B_LBR) begin
                    mode_q = MODE_CSI;
                    clear_params();
                end else if (ch == B_RBR) mode_q = MODE_OSC;
                else if (ch == B_LC_C) push_cmd(CMD_RESET, 0, 0, 0, 0);
            end
            MODE_CSI: begin
                if (ch >= B_FIN_LO && ch <= B_FIN_HI) begin
                    mode_q = MODE_GROUND;
                    csi_final(ch);
                end else if (ch >= B_ZERO && ch <= B_NINE) begin
                    if (!pdrop && pcount >= 1 && pcount <= NPARAM) begin
                        v = params[pcount-1] * 10 + (ch - B_ZERO);
                        params[pcount-1] = v > 65535 ? 16'hFFFF : 16'(v);
                    end
                end else if (ch == B_SEMI) begin
                    if (pcount < NPARAM) pcount++;
                    else pdrop = 1;
                end
            end
            default: begin
                if (ch == B_BEL || ch == B_ST) mode_q = MODE_GROUND;
                else if (ch == B_ESC) mode_q = MODE_ESCAPE;
            end
        endcase
    endfunction

    // send one byte beat, with a random gap ahead of it
    task automatic send_byte(logic [7:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        decode_byte(b);
        sent_count++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic send_number(int n);
        send_text($sformatf("%0d", n));
    endtask

    // command side: random stalls, compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command beat %0d", $time, cmd_ch.command);
                    error_count++;
                end else begin
                    t_result e;
                    t_result a;
                    e = expected_cmds.pop_front();
                    a.command = t_cmd_e'(cmd_ch.command);
                    a.code_point = cmd_ch.code_point;
                    a.move_count = cmd_ch.move_count;
                    a.target_row = cmd_ch.target_row;
                    a.target_col = cmd_ch.target_col;
                    a.style_bold = cmd_ch.style_bold;
                    a.style_fg_indexed = cmd_ch.style_fg_indexed;
                    a.style_fg_index = cmd_ch.style_fg_index;
                    if (a !== e) begin
                        $display("%0t: mismatch expected cmd=%0d cp=%h cnt=%0d row=%0d col=%0d",
                                 $time, e.command, e.code_point, e.move_count,
                                 e.target_row, e.target_col);
                        $display("      bold=%b idx_on=%b idx=%0d; actual cmd=%0d cp=%h",
                                 e.style_bold, e.style_fg_indexed, e.style_fg_index,
                                 a.command, a.code_point);
                        $display("      cnt=%0d row=%0d col=%0d bold=%b idx_on=%b idx=%0d",
                                 a.move_count, a.target_row, a.target_col, a.style_bold,
                                 a.style_fg_indexed, a.style_fg_index);
                        error_count++;
                    end
                end
            end
        end
        // mostly short stalls, now and then a long one
        if (!stall_enable) begin
            cmd_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            cmd_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            cmd_ch.ready <= 1'b0;
            stall_left <= $urandom_range(4, 20);
        end else begin
            cmd_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_ground_controls();
        send_byte(B_BS); send_byte(B_HT); send_byte(B_LF); send_byte(B_FF);
        send_byte(B_CR); send_byte(8'h00); send_byte(B_SPACE); send_byte(B_FIN_HI);
        send_byte(8'h7F); send_byte(8'hFF);
    endtask

    task automatic test_utf8();
        send_byte(8'hC3); send_byte(8'hA9);
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hE2); send_byte(8'h41);
        // multibyte character completes inside a csi sequence
        send_byte(B_ESC); send_byte(B_LBR); send_byte(8'hE2); send_byte(8'h82);
        send_byte(8'hAC); send_byte(F_A);
    endtask

    task automatic test_csi_moves();
        send_byte(B_CSI); send_text("0A");
        send_byte(B_ESC); send_text("[99999B");
        send_byte(B_ESC); send_text("[;7H");
        send_byte(B_ESC); send_text("[65535;1x2f");
        send_byte(B_ESC); send_text("[2J"); send_byte(B_ESC); send_text("[K");
        send_byte(B_ESC); send_text("[1;2;3;4;5;6;7;8;9;10C");
        send_byte(B_ESC); send_text("c");
        send_byte(B_ESC); send_text("7");
    endtask

    task automatic test_sgr_and_osc();
        send_byte(B_ESC); send_text("[1;35mX");
        send_byte(B_ESC); send_text("[38;5;300mY");
        send_byte(B_ESC); send_text("[38;2;9mZ");
        send_byte(B_ESC); send_text("[0mW");
        send_byte(B_OSC); send_text("title"); send_byte(B_BEL);
        send_byte(B_ESC); send_text("]x"); send_byte(B_ESC); send_text("\\");
        send_byte(B_ESC); send_text("]y"); send_byte(B_ST); send_text("q");
    endtask

    task automatic send_random_sequence();
        int k, n;
        k = $urandom_range(0, 99);
        if (k < 30) begin
            send_byte(8'($urandom_range(32, 126)));
        end else if (k < 70) begin
            if ($urandom_range(0, 3) == 0) send_byte(B_CSI);
            else begin send_byte(B_ESC); send_byte(B_LBR); end
            n = $urandom_range(0, NPARAM + 2);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0: ;
                    1: send_number($urandom_range(0, 9));
                    2: send_number($urandom_range(30, 38));
                    3: send_number($urandom_range(0, 300));
                    4: send_number($urandom_range(0, 99999));
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
                if (i < n - 1) send_byte(B_SEMI);
            end
            case ($urandom_range(0, 7))
                0: send_byte(F_A); 1: send_byte(F_B); 2: send_byte(F_C);
                3: send_byte(F_D); 4: send_byte($urandom_range(0, 1) ? F_H : F_F);
                5: send_byte($urandom_range(0, 1) ? F_J : F_K);
                6: send_byte(F_M);
                default: send_byte(8'($urandom_range(B_FIN_LO, B_FIN_HI)));
            endcase
        end else if (k < 80) begin
            n = $urandom_range(0, 3);
            send_byte(n == 0 ? 8'($urandom_range(8'hC0, 8'hDF)) :
                      n == 1 ? 8'($urandom_range(8'hE0, 8'hEF)) :
                               8'($urandom_range(8'hF0, 8'hF7)));
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (k < 88) begin
            send_byte($urandom_range(0, 1) ? B_OSC : B_ESC);
            send_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
            send_byte($urandom_range(0, 1) ? B_BEL : B_ST);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_stream();
        while (sent_count < BYTE_TARGET) begin
            send_random_sequence();
        end
    endtask

    initial begin
        int waited;
        byte_ch.valid = 1'b0;
        byte_ch.byte_in = 8'h00;
        decoder_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ground_controls();
        test_utf8();
        test_csi_moves();
        test_sgr_and_osc();
        test_random_stream();
        byte_ch.valid <= 1'b0;
        waited = 0;
        while (expected_cmds.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (NPARAM + 10) @(posedge i_clk);
        if (expected_cmds.size() != 0) begin
            $display("%0t: %0d expected commands never arrived", $time,
                     expected_cmds.size());
            error_count++;
        end
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/tep_pkg.sv
hw/rtl/tep_if.sv
hw/rtl/tep_ctrl.sv
hw/rtl/tep_datapath.sv
hw/rtl/tep_out_buf.sv
hw/rtl/terminal_escape_parser.sv
bench/terminal_escape_parser_tb.sv
